// ===== hw/rtl/mrdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Mixed-radix digit packer package
// Shared opcodes, constants and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrdp_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned FactorW   = WordW + 1;
  localparam int unsigned DivSteps  = WordW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam logic [7:0]  BYTE_MASK = 8'hff;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DIGIT = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;       // latch the input transfer and clear the result scratch
    logic load;        // load a chunk word
    logic need_chunk;  // report that a chunk is needed
    logic div_start;   // start the serial division
    logic div_step;    // one restoring division step
    logic grow;        // multiply the running factor by the radix
    logic take_rem;    // capture the remainder as the digit
    logic emit;        // emit the packed word and restart packing
    logic pack;        // add digit times factor to the packed word
    logic push;        // move the result into the output register
  } mrdp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       mode;
    logic       used_up;
    logic [1:0] op;
    logic       radix_zero;
    logic       div_last;
  } mrdp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mrdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mixed-radix digit packer controller
// Sequences one item at a time through decode, division, factor update and
// result hand-off, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mrdp_ctrl
  import mrdp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output      logic         in_stall_o,
  output      logic         out_valid_o,
  input  wire logic         out_stall_i,
  output      logic         cfg_ready_o,
  input  wire mrdp_status_t stat_i,
  output      mrdp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_GROW,
    S_PACK,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.clear = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        if (!stat_i.mode) begin
          case (stat_i.op)
            OP_LOAD: cmd_o.load = 1'b1;
            OP_DIGIT: begin
              if (stat_i.used_up) begin
                cmd_o.need_chunk = 1'b1;
              end else if (!stat_i.radix_zero) begin
                cmd_o.div_start = 1'b1;
                state_d         = S_DIV;
              end
            end
            default: ;
          endcase
        end else begin
          case (stat_i.op)
            OP_DIGIT: begin
              cmd_o.emit = stat_i.used_up;
              state_d    = S_PACK;
            end
            OP_FLUSH: cmd_o.emit = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_GROW;
        end
      end
      S_GROW: begin
        cmd_o.grow     = 1'b1;
        cmd_o.take_rem = 1'b1;
        state_d        = S_FIN;
      end
      S_PACK: begin
        // The product uses the factor before this digit's radix is applied.
        cmd_o.pack = 1'b1;
        cmd_o.grow = !stat_i.radix_zero;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrdp_datapath.sv =====
// ----------------------------------------------------------------------------
// Mixed-radix digit packer datapath
// Holds the chunk word, running factor and flags, a bit-serial restoring
// divider by the radix, the factor multiplier and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mrdp_datapath
  import mrdp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [WordW-1:0]   chunk_word_i,
  input  wire logic               end_of_data_i,
  input  wire logic [7:0]         radix_i,
  input  wire logic [7:0]         digit_in_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_decode_mode_i,
  input  wire mrdp_cmd_t          cmd_i,
  output      mrdp_status_t       stat_o,
  output      logic               status_o,
  output      logic [7:0]         digit_out_o,
  output      logic               word_valid_o,
  output      logic [WordW-1:0]   word_out_o,
  output      logic [2:0]         word_bytes_o,
  output      logic               finished_o
);

  localparam logic [FactorW-1:0] FullFactor = {1'b1, {WordW{1'b0}}};
  localparam int unsigned        ProdW      = FactorW + 8;

  // Architectural state.
  logic               mode_q, mode_d;
  logic               lcs_q, lcs_d;
  logic [WordW-1:0]   work_q, work_d;
  logic [FactorW-1:0] factor_q, factor_d;
  logic [7:0]         rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // Latched input transfer.
  logic [1:0]       op_q;
  logic [WordW-1:0] chunk_q;
  logic             eod_q;
  logic [7:0]       radix_q;
  logic [7:0]       digit_q;

  // Result scratch.
  logic             st_q;
  logic [7:0]       dig_q;
  logic             wv_q;
  logic [WordW-1:0] wd_q;
  logic [2:0]       wb_q;

  logic             used_up;
  logic [8:0]       div_r;
  logic             div_ge;
  logic [8:0]       div_diff;
  logic [ProdW-1:0] grow_prod;
  logic [FactorW-1:0] grow_sat;
  logic [WordW-1:0] madd;
  logic [WordW-1:0] fm1;
  logic [2:0]       emit_n;
  logic [WordW-1:0] emit_mask;

  assign used_up = (factor_q == '0) || factor_q[FactorW-1];

  assign stat_o.mode       = mode_q;
  assign stat_o.used_up    = used_up;
  assign stat_o.op         = op_q;
  assign stat_o.radix_zero = (radix_q == 8'd0);
  assign stat_o.div_last   = (cnt_q == DivCntW'(DivSteps - 1));

  // Restoring division: shift the next dividend bit into the remainder.
  assign div_r    = {rem_q, work_q[WordW-1]};
  assign div_ge   = (div_r >= {1'b0, radix_q});
  assign div_diff = div_r - {1'b0, radix_q};

  assign grow_prod = ProdW'(factor_q) * ProdW'(radix_q);
  assign grow_sat  = (grow_prod[ProdW-1:WordW] != '0) ? FullFactor
                                                       : grow_prod[FactorW-1:0];
  assign madd      = factor_q[WordW-1:0] * WordW'(digit_q);

  // Significant bytes are those needed to hold factor minus one.
  assign fm1 = factor_q[WordW-1:0] - WordW'(1);

  always_comb begin
    if (factor_q == '0 || fm1 == '0) begin
      emit_n = 3'd0;
    end else if (fm1[31:24] != '0) begin
      emit_n = 3'd4;
    end else if (fm1[23:16] != '0) begin
      emit_n = 3'd3;
    end else if (fm1[15:8] != '0) begin
      emit_n = 3'd2;
    end else begin
      emit_n = 3'd1;
    end
  end

  always_comb begin
    case (emit_n)
      3'd1:    emit_mask = {24'd0, BYTE_MASK};
      3'd2:    emit_mask = {16'd0, BYTE_MASK, BYTE_MASK};
      3'd3:    emit_mask = {8'd0, BYTE_MASK, BYTE_MASK, BYTE_MASK};
      3'd4:    emit_mask = {BYTE_MASK, BYTE_MASK, BYTE_MASK, BYTE_MASK};
      default: emit_mask = '0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    lcs_d    = lcs_q;
    work_d   = work_q;
    factor_d = factor_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;

    if (cfg_we_i) begin
      mode_d   = cfg_decode_mode_i;
      factor_d = FactorW'(cfg_decode_mode_i);
    end
    if (cmd_i.load) begin
      work_d   = lcs_q ? '0 : chunk_q;
      lcs_d    = lcs_q | eod_q;
      factor_d = FactorW'(1);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      work_d = {work_q[WordW-2:0], div_ge};
      rem_d  = div_ge ? div_diff[7:0] : div_r[7:0];
      cnt_d  = cnt_q + DivCntW'(1);
    end
    if (cmd_i.emit) begin
      work_d   = '0;
      factor_d = FactorW'(1);
    end
    if (cmd_i.pack) begin
      work_d = work_q + madd;
    end
    if (cmd_i.grow) begin
      factor_d = grow_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      lcs_q    <= 1'b0;
      work_q   <= '0;
      factor_q <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      lcs_q    <= lcs_d;
      work_q   <= work_d;
      factor_q <= factor_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      op_q    <= opcode_i;
      chunk_q <= chunk_word_i;
      eod_q   <= end_of_data_i;
      radix_q <= radix_i;
      digit_q <= digit_in_i;
      st_q    <= 1'b0;
      dig_q   <= '0;
      wv_q    <= 1'b0;
      wd_q    <= '0;
      wb_q    <= '0;
    end
    if (cmd_i.need_chunk) begin
      st_q <= 1'b1;
    end
    if (cmd_i.take_rem) begin
      dig_q <= rem_q;
    end
    if (cmd_i.emit) begin
      wv_q <= 1'b1;
      wd_q <= work_q & emit_mask;
      wb_q <= emit_n;
    end
    if (cmd_i.push) begin
      status_o     <= st_q;
      digit_out_o  <= dig_q;
      word_valid_o <= wv_q;
      word_out_o   <= wd_q;
      word_bytes_o <= wb_q;
      finished_o   <= !mode_q && lcs_q && used_up;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mixed_radix_digit_packer.sv =====
// Sequence: a load, flush, ignored opcode or rejected request goes from decode
// straight to result hand-off; a decode digit adds a pack step, and an encode digit
// request with a nonzero radix runs the 32-step serial divider and a factor update.
// Flow: one item at a time; the next item is taken once the result is registered,
// and a waiting result does not hold it off.
// Reset: asynchronous, active low; clears the word, factor, final-chunk flag and mode.
// ----------------------------------------------------------------------------
// Mixed-radix digit packer top level
// Splits chunk words into mixed-radix digits or packs digits into words.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_digit_packer
  import mrdp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [WordW-1:0] chunk_word_i,
  input  wire logic             end_of_data_i,
  input  wire logic [7:0]       radix_i,
  input  wire logic [7:0]       digit_in_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic             status_o,
  output      logic [7:0]       digit_out_o,
  output      logic             word_valid_o,
  output      logic [WordW-1:0] word_out_o,
  output      logic [2:0]       word_bytes_o,
  output      logic             finished_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic             cfg_decode_mode_i
);

  mrdp_cmd_t    cmd;
  mrdp_status_t stat;
  logic         cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  mrdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mrdp_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .chunk_word_i      (chunk_word_i),
    .end_of_data_i     (end_of_data_i),
    .radix_i           (radix_i),
    .digit_in_i        (digit_in_i),
    .cfg_we_i          (cfg_we),
    .cfg_decode_mode_i (cfg_decode_mode_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .digit_out_o       (digit_out_o),
    .word_valid_o      (word_valid_o),
    .word_out_o        (word_out_o),
    .word_bytes_o      (word_bytes_o),
    .finished_o        (finished_o)
  );

endmodule

`default_nettype wire

// ===== bench/mixed_radix_digit_packer_checker.sv =====
// ----------------------------------------------------------------------------
// Mixed-radix digit packer checker
// Watches the input, result and mode-write channels of the packer, predicts
// the result of every input transfer and compares each result transfer with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module mixed_radix_digit_packer_checker
  import mrdp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       opcode_i,
  input  logic [WordW-1:0] chunk_word_i,
  input  logic             end_of_data_i,
  input  logic [7:0]       radix_i,
  input  logic [7:0]       digit_in_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             status_i,
  input  logic [7:0]       digit_out_i,
  input  logic             word_valid_i,
  input  logic [WordW-1:0] word_out_i,
  input  logic [2:0]       word_bytes_i,
  input  logic             finished_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic             cfg_decode_mode_i,
  output int unsigned      mismatches_o,
  output int unsigned      outstanding_o
);

  typedef struct packed {
    logic             status;
    logic [7:0]       digit;
    logic             word_valid;
    logic [WordW-1:0] word;
    logic [2:0]       bytes;
    logic             finished;
  } packer_out_t;

  localparam logic [FactorW-1:0] FullFactor = {1'b1, {WordW{1'b0}}};

  logic               decode_q;
  logic [WordW-1:0]   work_q;
  logic [FactorW-1:0] factor_q;
  logic               final_chunk_q;
  packer_out_t        owed_results[$];
  int unsigned        mismatches;

  function automatic logic exhausted(logic [FactorW-1:0] f);
    return (f == '0) || f[WordW];
  endfunction

  // The factor saturates at 2^32 instead of wrapping.
  function automatic logic [FactorW-1:0] grown_factor(logic [FactorW-1:0] f, logic [7:0] r);
    logic [FactorW+7:0] p;
    p = f * r;
    return (p >= FullFactor) ? FullFactor : p[FactorW-1:0];
  endfunction

  // The byte count is the number of bytes needed to hold (factor - 1).
  function automatic packer_out_t packed_word(logic [WordW-1:0] w, logic [FactorW-1:0] f);
    packer_out_t        r;
    logic [FactorW-1:0] span;
    int unsigned        n;
    r = '0;
    n = 0;
    if (f != '0) begin
      span = f - 1'b1;
      while (span != '0 && n < 4) begin
        n++;
        span = span >> 8;
      end
    end
    r.word_valid = 1'b1;
    r.bytes = 3'(n);
    r.word = (n >= 4) ? w : (w & ((32'h1 << (8 * n)) - 32'h1));
    return r;
  endfunction

  function automatic packer_out_t step_packer(logic [1:0] op, logic [WordW-1:0] chunk,
                                              logic eod, logic [7:0] radix, logic [7:0] digit);
    packer_out_t r;
    r = '0;
    if (!decode_q) begin
      if (op == OP_LOAD) begin
        work_q = final_chunk_q ? '0 : chunk;
        if (eod) final_chunk_q = 1'b1;
        factor_q = FactorW'(1);
      end else if (op == OP_DIGIT) begin
        if (exhausted(factor_q)) begin
          r.status = 1'b1;
        end else if (radix != '0) begin
          r.digit = 8'(work_q % radix);
          work_q = work_q / radix;
          factor_q = grown_factor(factor_q, radix);
        end
      end
      r.finished = final_chunk_q && exhausted(factor_q);
    end else begin
      if (op == OP_DIGIT) begin
        if (exhausted(factor_q)) begin
          r = packed_word(work_q, factor_q);
          work_q = '0;
          factor_q = FactorW'(1);
        end
        work_q = work_q + digit * factor_q[WordW-1:0];
        if (radix != '0) factor_q = grown_factor(factor_q, radix);
      end else if (op == OP_FLUSH) begin
        r = packed_word(work_q, factor_q);
        work_q = '0;
        factor_q = FactorW'(1);
      end
    end
    return r;
  endfunction

  function automatic void compare_field(string field, logic [WordW-1:0] want,
                                        logic [WordW-1:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    packer_out_t want;
    if (!rst_ni) begin
      decode_q = 1'b0;
      work_q = '0;
      factor_q = '0;
      final_chunk_q = 1'b0;
      owed_results.delete();
      mismatches = 0;
      mismatches_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        decode_q = cfg_decode_mode_i;
        factor_q = FactorW'(cfg_decode_mode_i);
      end
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(step_packer(opcode_i, chunk_word_i, end_of_data_i,
                                           radix_i, digit_in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          if (mismatches < 10) $display("%0t: result transfer with none outstanding", $time);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          compare_field("status", 32'(want.status), 32'(status_i));
          compare_field("digit_out", 32'(want.digit), 32'(digit_out_i));
          compare_field("word_valid", 32'(want.word_valid), 32'(word_valid_i));
          compare_field("word_out", want.word, word_out_i);
          compare_field("word_bytes", 32'(want.bytes), 32'(word_bytes_i));
          compare_field("finished", 32'(want.finished), 32'(finished_i));
        end
      end
      mismatches_o <= mismatches;
      outstanding_o <= owed_results.size();
    end
  end

endmodule

// ===== bench/mixed_radix_digit_packer_tb.sv =====
// ----------------------------------------------------------------------------
// Mixed-radix digit packer testbench
// Drives directed and random load, digit and flush transfers in both modes,
// with random gaps on the input and random stalls on the result channel. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module mixed_radix_digit_packer_tb;
  import mrdp_pkg::*;

  localparam logic [1:0]  OP_NONE    = 2'd3;
  localparam int unsigned StallLimit = 2000;

  logic             clk_i;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  logic             in_stall_o;
  logic [1:0]       opcode_i          = OP_LOAD;
  logic [WordW-1:0] chunk_word_i      = '0;
  logic             end_of_data_i     = 1'b0;
  logic [7:0]       radix_i           = '0;
  logic [7:0]       digit_in_i        = '0;
  logic             out_valid_o;
  logic             out_stall_i       = 1'b0;
  logic             status_o;
  logic [7:0]       digit_out_o;
  logic             word_valid_o;
  logic [WordW-1:0] word_out_o;
  logic [2:0]       word_bytes_o;
  logic             finished_o;
  logic             cfg_valid_i       = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_decode_mode_i = 1'b0;

  logic             quiet             = 1'b0;
  int unsigned      stall_left        = 0;
  int unsigned      mismatches;
  int unsigned      outstanding;

  mixed_radix_digit_packer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .chunk_word_i      (chunk_word_i),
    .end_of_data_i     (end_of_data_i),
    .radix_i           (radix_i),
    .digit_in_i        (digit_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .digit_out_o       (digit_out_o),
    .word_valid_o      (word_valid_o),
    .word_out_o        (word_out_o),
    .word_bytes_o      (word_bytes_o),
    .finished_o        (finished_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_decode_mode_i (cfg_decode_mode_i)
  );

  mixed_radix_digit_packer_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .chunk_word_i      (chunk_word_i),
    .end_of_data_i     (end_of_data_i),
    .radix_i           (radix_i),
    .digit_in_i        (digit_in_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_i          (status_o),
    .digit_out_i       (digit_out_o),
    .word_valid_i      (word_valid_o),
    .word_out_i        (word_out_o),
    .word_bytes_i      (word_bytes_o),
    .finished_i        (finished_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_decode_mode_i (cfg_decode_mode_i),
    .mismatches_o      (mismatches),
    .outstanding_o     (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short idle spans, now and then a long one.
  function automatic int unsigned pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_radix();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'd0;
    if (r < 7) return 8'd1;
    if (r < 17) return 8'($urandom_range(2, 4));
    if (r < 25) return 8'd255;
    return 8'($urandom_range(2, 255));
  endfunction

  // Result-side stalls alternate with free stretches of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left <= pick_span();
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_span();
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("mixed_radix_digit_packer_tb failed");
    $finish;
  end

  // Returns at the clock edge where the input transfer took place; valid stays
  // high so that a following item without a gap keeps it up.
  task automatic offer_item(logic [1:0] op, logic [WordW-1:0] chunk, logic eod,
                            logic [7:0] radix, logic [7:0] digit);
    int unsigned gap;
    gap = quiet ? 0 : pick_span();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    chunk_word_i <= chunk;
    end_of_data_i <= eod;
    radix_i <= radix;
    digit_in_i <= digit;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_decode_mode(logic mode);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_decode_mode_i <= mode;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly a load followed by digit requests until the chunk is used up, with
  // early reloads, extra requests and stray opcodes mixed in.
  task automatic split_words(int unsigned count, bit allow_final);
    int unsigned     sent;
    int unsigned     steps;
    int unsigned     limit;
    longint unsigned product;
    logic [7:0]      rad;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 82) begin
        offer_item(OP_LOAD, $urandom, allow_final && ($urandom_range(0, 24) == 0),
                   8'($urandom), 8'($urandom));
        sent++;
        product = 1;
        steps = 0;
        limit = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 40;
        while (product < 64'h1_0000_0000 && steps < limit) begin
          rad = pick_radix();
          offer_item(OP_DIGIT, $urandom, 1'b0, rad, 8'($urandom_range(0, 254)));
          if (rad > 1) product = product * rad;
          steps++;
          sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
          offer_item(OP_DIGIT, $urandom, 1'b0, pick_radix(), 8'($urandom_range(0, 254)));
          sent++;
        end
      end else begin
        offer_item(2'($urandom_range(0, 3)), $urandom,
                   allow_final && ($urandom_range(0, 1) == 1), pick_radix(),
                   8'($urandom_range(0, 254)));
        sent++;
      end
    end
  endtask

  // Runs of digits, mostly below their radix, usually closed by a flush; long
  // runs overflow the factor and force a word out on the next digit.
  task automatic pack_digits(int unsigned count);
    int unsigned sent;
    int unsigned run;
    logic [7:0]  rad;
    logic [7:0]  dig;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 5);
        repeat (run) begin
          rad = pick_radix();
          dig = (rad > 1 && $urandom_range(0, 9) != 0) ? 8'($urandom_range(0, rad - 1))
                                                        : 8'($urandom_range(0, 254));
          offer_item(OP_DIGIT, $urandom, 1'($urandom), rad, dig);
          sent++;
        end
        if ($urandom_range(0, 9) < 6) begin
          offer_item(OP_FLUSH, $urandom, 1'($urandom), pick_radix(),
                     8'($urandom_range(0, 254)));
          sent++;
        end
      end else begin
        offer_item(2'($urandom_range(0, 3)), $urandom, 1'($urandom), pick_radix(),
                   8'($urandom_range(0, 254)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encode: request before any chunk, ignored opcodes, radix zero and one,
    // saturation at 2^32, request after the chunk is used up, reloads.
    set_decode_mode(1'b0);
    offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd7, 8'd0);
    offer_item(OP_FLUSH, 32'h0, 1'b0, 8'd7, 8'd0);
    offer_item(OP_NONE, 32'h0, 1'b0, 8'd7, 8'd0);
    offer_item(OP_LOAD, 32'hffff_ffff, 1'b0, 8'd0, 8'd0);
    offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd0, 8'd0);
    offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd1, 8'd0);
    repeat (6) offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd255, 8'd0);
    offer_item(OP_LOAD, 32'h8000_0001, 1'b0, 8'd0, 8'd0);
    offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd2, 8'd0);
    offer_item(OP_LOAD, 32'h0, 1'b0, 8'd0, 8'd0);

    // Decode: digit above its radix, radix zero, ignored load, flush of an
    // empty word, and a long run that wraps the word and overflows the factor.
    set_decode_mode(1'b1);
    offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd2, 8'd254);
    offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd0, 8'd5);
    offer_item(OP_LOAD, 32'hffff_ffff, 1'b1, 8'd0, 8'd0);
    offer_item(OP_FLUSH, 32'h0, 1'b0, 8'd0, 8'd0);
    offer_item(OP_FLUSH, 32'h0, 1'b0, 8'd0, 8'd0);
    repeat (6) offer_item(OP_DIGIT, 32'h0, 1'b0, 8'd255, 8'd254);
    offer_item(OP_FLUSH, 32'h0, 1'b0, 8'd0, 8'd0);

    set_decode_mode(1'b0);
    quiet <= 1'b1;
    split_words(60, 1'b0);
    quiet <= 1'b0;
    split_words(250, 1'b0);

    set_decode_mode(1'b1);
    pack_digits(220);
    quiet <= 1'b1;
    pack_digits(80);
    quiet <= 1'b0;

    set_decode_mode(1'b0);
    split_words(150, 1'b0);
    set_decode_mode(1'b1);
    pack_digits(100);

    // The final chunk is sticky, so it is only marked in the last phase.
    set_decode_mode(1'b0);
    offer_item(OP_LOAD, 32'h1234_5678, 1'b1, 8'd0, 8'd0);
    offer_item(OP_LOAD, 32'hffff_ffff, 1'b0, 8'd0, 8'd0);
    split_words(100, 1'b1);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mixed_radix_digit_packer_tb passed");
    end else begin
      $display("mixed_radix_digit_packer_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mrdp_pkg.sv
hw/rtl/mrdp_ctrl.sv
hw/rtl/mrdp_datapath.sv
hw/rtl/mixed_radix_digit_packer.sv
bench/mixed_radix_digit_packer_checker.sv
bench/mixed_radix_digit_packer_tb.sv
